// File: hw/rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the WebSocket frame deframer files.
// ----------------------------------------------------------------------------
package wsd_pkg;

	// Result kinds on the output channel.
	typedef enum logic [1:0] {
		KIND_PAYLOAD   = 2'd0,
		KIND_EMPTY_END = 2'd1,
		KIND_CLOSE     = 2'd2,
		KIND_PONG      = 2'd3
	} kind_t;

	// Frame opcodes that get special handling.
	localparam logic [3:0] OP_MAX_DATA = 4'h2;
	localparam logic [3:0] OP_CLOSE    = 4'h8;
	localparam logic [3:0] OP_PING     = 4'h9;

	// Seven-bit length codes that announce an extended length.
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// Byte counts of the header extensions.
	localparam logic [3:0] HC_EXT16 = 4'd2;
	localparam logic [3:0] HC_EXT64 = 4'd8;
	localparam logic [3:0] HC_KEY   = 4'd4;

	// One result as produced by the parser for the byte it is given.
	typedef struct packed {
		logic       emit;
		kind_t      kind;
		logic [7:0] data;
		logic [3:0] opcode;
		logic       fin;
		logic       last;
	} parse_t;

endpackage

// File: hw/rtl/wsd_byte_if.sv
// ----------------------------------------------------------------------------
// wsd_byte_if
// Valid/ready channel that carries one received byte per transfer.
// ----------------------------------------------------------------------------
interface wsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/wsd_result_if.sv
// ----------------------------------------------------------------------------
// wsd_result_if
// Valid/ready channel that carries one deframer result per transfer.
// ----------------------------------------------------------------------------
interface wsd_result_if;
	logic            valid;
	logic            ready;
	wsd_pkg::kind_t  kind;
	logic [7:0]      data;
	logic [3:0]      frame_opcode;
	logic            final_fragment;
	logic            last_of_frame;

	modport source (output valid, output kind, output data, output frame_opcode,
		output final_fragment, output last_of_frame, input ready);
	modport sink   (input valid, input kind, input data, input frame_opcode,
		input final_fragment, input last_of_frame, output ready);
endinterface

// File: hw/rtl/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header state machine and payload unmasking. The result for the
// presented byte is combinational; the state advances when step is high.
// ----------------------------------------------------------------------------
module wsd_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [7:0]      rx_byte,
	output wsd_pkg::parse_t res
);
	import wsd_pkg::*;

	typedef enum logic [5:0] {
		PH_HDR0    = 6'b000001,
		PH_HDR1    = 6'b000010,
		PH_EXTLEN  = 6'b000100,
		PH_KEY     = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_CLOSED  = 6'b100000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  hc_q, hc_d;
	logic        fin_q, fin_d;
	logic [3:0]  op_q, op_d;
	logic        masked_q, masked_d;
	logic [31:0] key_q, key_d;
	logic [63:0] rem_q, rem_d;
	logic [1:0]  ki_q, ki_d;

	logic [63:0] rem_chk;
	logic [63:0] rem_shift;
	logic        len_done;
	logic        len_masked;
	logic        hdr_done;
	logic        end_req;
	logic        end_empty;
	logic        is_data;
	logic [7:0]  kb;

	assign is_data   = (op_q <= OP_MAX_DATA);
	assign rem_shift = {rem_q[55:0], rx_byte};

	// Key byte for the current payload position, first key byte first.
	always_comb begin
		case (ki_q)
			2'd0:    kb = key_q[31:24];
			2'd1:    kb = key_q[23:16];
			2'd2:    kb = key_q[15:8];
			default: kb = key_q[7:0];
		endcase
	end

	// Next state and result for the presented byte.
	always_comb begin
		phase_d    = phase_q;
		hc_d       = hc_q;
		fin_d      = fin_q;
		op_d       = op_q;
		masked_d   = masked_q;
		key_d      = key_q;
		rem_d      = rem_q;
		ki_d       = ki_q;
		rem_chk    = rem_q;
		len_done   = 1'b0;
		len_masked = masked_q;
		hdr_done   = 1'b0;
		end_req    = 1'b0;
		end_empty  = 1'b0;
		res.emit   = 1'b0;
		res.kind   = KIND_PAYLOAD;
		res.data   = 8'h00;
		res.opcode = op_q;
		res.fin    = fin_q;
		res.last   = 1'b0;

		unique case (phase_q)
			PH_HDR0: begin
				fin_d   = rx_byte[7];
				op_d    = rx_byte[3:0];
				phase_d = PH_HDR1;
			end
			PH_HDR1: begin
				masked_d   = rx_byte[7];
				len_masked = rx_byte[7];
				rem_d      = 64'd0;
				if (rx_byte[6:0] == LEN_EXT16) begin
					hc_d    = HC_EXT16;
					phase_d = PH_EXTLEN;
				end else if (rx_byte[6:0] == LEN_EXT64) begin
					hc_d    = HC_EXT64;
					phase_d = PH_EXTLEN;
				end else begin
					rem_d    = {57'd0, rx_byte[6:0]};
					rem_chk  = {57'd0, rx_byte[6:0]};
					len_done = 1'b1;
				end
			end
			PH_EXTLEN: begin
				rem_d   = rem_shift;
				rem_chk = rem_shift;
				hc_d    = hc_q - 4'd1;
				if (hc_q == 4'd1) begin
					len_done = 1'b1;
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], rx_byte};
				hc_d  = hc_q - 4'd1;
				if (hc_q == 4'd1) begin
					hdr_done = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				ki_d  = ki_q + 2'd1;
				rem_d = rem_q - 64'd1;
				if (is_data) begin
					res.emit = 1'b1;
					res.data = rx_byte ^ (masked_q ? kb : 8'h00);
					res.last = (rem_q == 64'd1);
					if (rem_q == 64'd1) begin
						phase_d = PH_HDR0;
					end
				end else if (rem_q == 64'd1) begin
					end_req = 1'b1;
				end
			end
			PH_CLOSED: begin
			end
			default: begin
				phase_d = PH_HDR0;
			end
		endcase

		// Length complete: the masking key follows, or the header is over.
		if (len_done) begin
			if (len_masked) begin
				phase_d = PH_KEY;
				hc_d    = HC_KEY;
				key_d   = 32'd0;
			end else begin
				hdr_done = 1'b1;
			end
		end

		// Header complete: start the payload or end an empty frame.
		if (hdr_done) begin
			ki_d = 2'd0;
			if (rem_chk == 64'd0) begin
				end_req   = 1'b1;
				end_empty = 1'b1;
			end else begin
				phase_d = PH_PAYLOAD;
			end
		end

		// Frame end without a payload byte result.
		if (end_req) begin
			phase_d = PH_HDR0;
			if (op_q == OP_CLOSE) begin
				res.emit = 1'b1;
				res.kind = KIND_CLOSE;
				res.last = 1'b1;
				phase_d  = PH_CLOSED;
			end else if (op_q == OP_PING) begin
				res.emit = 1'b1;
				res.kind = KIND_PONG;
				res.last = 1'b1;
			end else if (end_empty && is_data) begin
				res.emit = 1'b1;
				res.kind = KIND_EMPTY_END;
				res.last = 1'b1;
			end
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			hc_q     <= 4'd0;
			fin_q    <= 1'b0;
			op_q     <= 4'd0;
			masked_q <= 1'b0;
			key_q    <= 32'd0;
			rem_q    <= 64'd0;
			ki_q     <= 2'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			hc_q     <= hc_d;
			fin_q    <= fin_d;
			op_q     <= op_d;
			masked_q <= masked_d;
			key_q    <= key_d;
			rem_q    <= rem_d;
			ki_q     <= ki_d;
		end
	end

endmodule

// File: hw/rtl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser: one byte in per transfer, at most one
// result (payload byte, empty frame end, close or pong request) out.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register and parsed from there;
// its result is held in the result register and offered from it.
// Throughput: one byte per cycle while the result channel does not stall; the
// critical path is the 64-bit length decrement and compare in the parser.
// Reset: arst_n clears the parser to the first header byte and empties the
// input and output registers.
module websocket_frame_deframer (
	input  logic         clk,
	input  logic         arst_n,
	wsd_byte_if.sink     rx,
	wsd_result_if.source msg
);
	import wsd_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       out_vld_q;
	parse_t     res;
	parse_t     out_q;

	assign advance  = vld_s1 && (!out_vld_q || msg.ready);
	assign rx.ready = !vld_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rx.ready) begin
			vld_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	wsd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.res     (res)
	);

	// Result register; it drains on a transfer and refills behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= res.emit;
		end else if (msg.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign msg.valid          = out_vld_q;
	assign msg.kind           = out_q.kind;
	assign msg.data           = out_q.data;
	assign msg.frame_opcode   = out_q.opcode;
	assign msg.final_fragment = out_q.fin;
	assign msg.last_of_frame  = out_q.last;

endmodule

// File: sim/websocket_frame_deframer_tb.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb
// Feeds a byte stream of WebSocket frames into the deframer and checks every
// result against a cycle-free parser model kept in this bench. A short set
// of hand-picked frames comes first, then random well-formed frames of all
// opcodes but close, length forms and mask settings, and finally a close frame with
// trailing bytes that must be ignored. Both channels stall at random.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wsd_pkg::*;

	// Opcodes without a name in the package.
	localparam logic [3:0] OP_CONT = 4'h0;
	localparam logic [3:0] OP_TEXT = 4'h1;

	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned PRINT_LIMIT  = 40;
	localparam int unsigned STREAM_BYTES = 540;

	// Parser phases of the bench model.
	typedef enum logic [2:0] {
		ST_HDR0,
		ST_HDR1,
		ST_EXTLEN,
		ST_KEY,
		ST_PAYLOAD,
		ST_CLOSED
	} ws_phase_t;

	// How the payload length is written in the header.
	typedef enum int unsigned {LEN_7BIT, LEN_16BIT, LEN_64BIT} len_form_t;

	// Stall pattern of the two channels.
	typedef enum int unsigned {PACE_SINK_SLOW, PACE_SOURCE_SLOW, PACE_FULL} pace_t;

	typedef struct {
		logic [7:0] data;
		pace_t      pace;
	} rx_item_t;

	logic clk;
	logic arst_n;

	wsd_byte_if   byte_ch ();
	wsd_result_if result_ch ();

	websocket_frame_deframer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (byte_ch),
		.msg    (result_ch)
	);

	rx_item_t    stream_q[$];
	parse_t      pending_results[$];
	pace_t       link_pace;
	int unsigned bytes_queued;
	int unsigned mismatch_count;
	int unsigned quiet_cycles;
	bit          run_done;

	// Model state of the frame parser.
	ws_phase_t   ws_phase;
	logic [3:0]  ws_hdr_left;
	logic        ws_fin;
	logic [3:0]  ws_opcode;
	logic        ws_masked;
	logic [31:0] ws_key;
	logic [63:0] ws_remaining;
	logic [1:0]  ws_key_idx;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned source_gap_pct(pace_t p);
		case (p)
			PACE_SINK_SLOW:   return 26;
			PACE_SOURCE_SLOW: return 47;
			default:          return 0;
		endcase
	endfunction

	function automatic int unsigned sink_stall_pct(pace_t p);
		case (p)
			PACE_SINK_SLOW:   return 47;
			PACE_SOURCE_SLOW: return 26;
			default:          return 0;
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatch_count < PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// Queue one byte; the stall pattern moves on with the position in the stream.
	task automatic queue_byte(input logic [7:0] b);
		rx_item_t item;
		item.data = b;
		if (bytes_queued < STREAM_BYTES / 3)
			item.pace = PACE_SINK_SLOW;
		else if (bytes_queued < 2 * STREAM_BYTES / 3)
			item.pace = PACE_SOURCE_SLOW;
		else
			item.pace = PACE_FULL;
		stream_q.push_back(item);
		bytes_queued++;
	endtask

	// Queue a whole frame: header, extended length, key and random payload.
	task automatic send_frame(input logic [7:0] hdr0, input int unsigned len,
		input len_form_t form, input logic with_key, input logic [31:0] key);
		logic [63:0] len64;
		len64 = 64'(len);
		queue_byte(hdr0);
		case (form)
			LEN_7BIT: queue_byte({with_key, len64[6:0]});
			LEN_16BIT: begin
				queue_byte({with_key, LEN_EXT16});
				queue_byte(len64[15:8]);
				queue_byte(len64[7:0]);
			end
			default: begin
				queue_byte({with_key, LEN_EXT64});
				for (int i = 7; i >= 0; i--)
					queue_byte(len64[8*i +: 8]);
			end
		endcase
		if (with_key)
			for (int i = 3; i >= 0; i--)
				queue_byte(key[8*i +: 8]);
		repeat (len) queue_byte(8'($urandom));
	endtask

	function automatic void push_result(kind_t k, logic [7:0] d, logic ends);
		parse_t r;
		r.emit   = 1'b1;
		r.kind   = k;
		r.data   = d;
		r.opcode = ws_opcode;
		r.fin    = ws_fin;
		r.last   = ends;
		pending_results.push_back(r);
	endfunction

	// A frame ended on a header byte or on a dropped payload byte.
	function automatic void close_out_frame(bit empty);
		ws_phase = ST_HDR0;
		if (ws_opcode == OP_CLOSE) begin
			push_result(KIND_CLOSE, 8'h00, 1'b1);
			ws_phase = ST_CLOSED;
		end else if (ws_opcode == OP_PING) begin
			push_result(KIND_PONG, 8'h00, 1'b1);
		end else if (empty && ws_opcode <= OP_MAX_DATA) begin
			push_result(KIND_EMPTY_END, 8'h00, 1'b1);
		end
	endfunction

	function automatic void start_payload();
		ws_key_idx = '0;
		if (ws_remaining == '0)
			close_out_frame(1'b1);
		else
			ws_phase = ST_PAYLOAD;
	endfunction

	function automatic void length_known();
		if (ws_masked) begin
			ws_phase    = ST_KEY;
			ws_hdr_left = HC_KEY;
			ws_key      = '0;
		end else begin
			start_payload();
		end
	endfunction

	// Advance the parser model by one accepted byte.
	function automatic void parse_byte(logic [7:0] b);
		logic [7:0] key_byte;
		case (ws_phase)
			ST_HDR0: begin
				ws_fin    = b[7];
				ws_opcode = b[3:0];
				ws_phase  = ST_HDR1;
			end
			ST_HDR1: begin
				ws_masked    = b[7];
				ws_remaining = '0;
				if (b[6:0] == LEN_EXT16) begin
					ws_hdr_left = HC_EXT16;
					ws_phase    = ST_EXTLEN;
				end else if (b[6:0] == LEN_EXT64) begin
					ws_hdr_left = HC_EXT64;
					ws_phase    = ST_EXTLEN;
				end else begin
					ws_remaining = 64'(b[6:0]);
					length_known();
				end
			end
			ST_EXTLEN: begin
				ws_remaining = {ws_remaining[55:0], b};
				ws_hdr_left  = ws_hdr_left - 4'd1;
				if (ws_hdr_left == '0)
					length_known();
			end
			ST_KEY: begin
				ws_key      = {ws_key[23:0], b};
				ws_hdr_left = ws_hdr_left - 4'd1;
				if (ws_hdr_left == '0)
					start_payload();
			end
			ST_PAYLOAD: begin
				key_byte     = ws_masked ? ws_key[31 - 8*ws_key_idx -: 8] : 8'h00;
				ws_key_idx   = ws_key_idx + 2'd1;
				ws_remaining = ws_remaining - 64'd1;
				if (ws_opcode <= OP_MAX_DATA) begin
					push_result(KIND_PAYLOAD, b ^ key_byte, ws_remaining == '0);
					if (ws_remaining == '0)
						ws_phase = ST_HDR0;
				end else if (ws_remaining == '0) begin
					close_out_frame(1'b0);
				end
			end
			default: begin
				// Everything after a close request is ignored.
			end
		endcase
	endfunction

	// Byte driver: the model sees each byte at the edge where it transfers.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid   <= 1'b0;
			byte_ch.rx_byte <= '0;
		end else begin
			if (byte_ch.valid && byte_ch.ready)
				parse_byte(byte_ch.rx_byte);
			if (!byte_ch.valid || byte_ch.ready) begin
				if (stream_q.size() > 0 &&
					$urandom_range(0, 99) >= source_gap_pct(stream_q[0].pace)) begin
					byte_ch.valid   <= 1'b1;
					byte_ch.rx_byte <= stream_q[0].data;
					link_pace       <= stream_q[0].pace;
					void'(stream_q.pop_front());
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each transfer with the oldest expected result.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		parse_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result kind %0d with none expected",
						result_ch.kind));
				end else begin
					want = pending_results.pop_front();
					if (result_ch.kind !== want.kind)
						report_mismatch($sformatf("kind %0d, expected %0d",
							result_ch.kind, want.kind));
					if (result_ch.data !== want.data)
						report_mismatch($sformatf("data %h, expected %h",
							result_ch.data, want.data));
					if (result_ch.frame_opcode !== want.opcode)
						report_mismatch($sformatf("frame_opcode %h, expected %h",
							result_ch.frame_opcode, want.opcode));
					if (result_ch.final_fragment !== want.fin)
						report_mismatch($sformatf("final_fragment %b, expected %b",
							result_ch.final_fragment, want.fin));
					if (result_ch.last_of_frame !== want.last)
						report_mismatch($sformatf("last_of_frame %b, expected %b",
							result_ch.last_of_frame, want.last));
				end
			end
			result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct(link_pace));
		end
	end

	// Watchdog: too long without any transfer on either channel ends the run.
	always @(posedge clk) begin
		if (arst_n && !run_done) begin
			if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin : stimulus
		int unsigned pick;
		int unsigned len;
		logic [3:0]  op;
		len_form_t   form;
		logic [31:0] key;

		arst_n            = 1'b0;
		byte_ch.valid     = 1'b0;
		byte_ch.rx_byte   = '0;
		result_ch.ready   = 1'b0;
		link_pace         = PACE_SINK_SLOW;
		bytes_queued      = 0;
		mismatch_count    = 0;
		quiet_cycles      = 0;
		run_done          = 1'b0;
		ws_phase          = ST_HDR0;
		ws_hdr_left       = '0;
		ws_fin            = 1'b0;
		ws_opcode         = '0;
		ws_masked         = 1'b0;
		ws_key            = '0;
		ws_remaining      = '0;
		ws_key_idx        = '0;

		// Masked empty text frame, unmasked binary fragment with a 64-bit
		// length, and a masked ping with reserved bits set and a 16-bit length.
		send_frame({4'h8, OP_TEXT}, 0, LEN_7BIT, 1'b1, 32'h1234_5678);
		send_frame({4'h0, OP_MAX_DATA}, 2, LEN_64BIT, 1'b0, 32'h0);
		send_frame({4'hF, OP_PING}, 1, LEN_16BIT, 1'b1, 32'hFFFF_FFFF);

		// Random well-formed frames; lengths stay short so most bytes make results.
		while (bytes_queued < STREAM_BYTES - 15) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				op = 4'($urandom_range(OP_CONT, OP_MAX_DATA));
			end else if (pick < 72) begin
				op = OP_PING;
			end else begin
				// Opcodes whose payload is dropped, skipping close and ping.
				op = 4'($urandom_range(OP_MAX_DATA + 1, 13));
				if (op >= OP_CLOSE)
					op = op + 4'd2;
			end
			pick = $urandom_range(0, 99);
			if (pick < 40)
				len = $urandom_range(0, 3);
			else if (pick < 75)
				len = $urandom_range(4, 12);
			else if (pick < 93)
				len = $urandom_range(13, 40);
			else if (pick < 99)
				len = $urandom_range(120, 131);
			else
				len = $urandom_range(200, 300);
			if (len > 125 || $urandom_range(0, 3) == 0)
				form = len_form_t'($urandom_range(LEN_16BIT, LEN_64BIT));
			else
				form = LEN_7BIT;
			pick = $urandom_range(0, 7);
			key = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
			send_frame({4'($urandom_range(0, 15)), op}, len, form,
				1'($urandom_range(0, 1)), key);
		end

		// Close frame, then bytes that the block must ignore.
		send_frame({4'($urandom_range(0, 15)), OP_CLOSE}, $urandom_range(0, 3),
			len_form_t'($urandom_range(LEN_7BIT, LEN_64BIT)), 1'($urandom_range(0, 1)),
			$urandom);
		repeat (8) queue_byte(8'($urandom));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (stream_q.size() != 0 || byte_ch.valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		run_done = 1'b1;

		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
